@@ design/waypoint_ring_sequencer_macros.svh @@
// Assertion macros used by the design file wrs_dp.sv.
`ifndef WAYPOINT_RING_SEQUENCER_MACROS_SVH
`define WAYPOINT_RING_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wrs assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define WRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wrs assertion failed");

`endif

@@ design/wrs_pkg.sv @@
`default_nettype none
package wrs_pkg;

  localparam int WRS_RING_DEPTH_DEF = 64;
  localparam int WRS_POS_W = 7;
  localparam int WRS_MOD_W = 8;
  localparam int WRS_CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_ADV   = 2'd2,
    KIND_QUERY = 2'd3
  } kind_t;

  typedef enum logic [WRS_CFG_IDX_W-1:0] {
    REG_SHIFT_N = 3'd0,
    REG_SHIFT_E = 3'd1,
    REG_SHIFT_D = 3'd2,
    REG_GAIN    = 3'd3,
    REG_SIZE    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         slot;
    logic [5:0]         first_slot;
    logic [6:0]         points_in_use;
    logic [5:0]         rel_index;
    logic signed [31:0] wp_north;
    logic signed [31:0] wp_east;
    logic signed [31:0] wp_down;
    logic [31:0]        wp_speed;
    logic signed [31:0] own_north;
    logic signed [31:0] own_east;
    logic signed [31:0] own_down;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] point_north;
    logic signed [31:0] point_east;
    logic signed [31:0] point_down;
    logic [31:0]        point_speed;
    logic               seg_avail;
    logic [5:0]         head_now;
    logic [6:0]         count_now;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] n;
    logic signed [31:0] e;
    logic signed [31:0] d;
    logic [31:0]        speed;
  } wp_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISP, ST_ADV_MOD, ST_ADV_CHK, ST_RD, ST_DIFF, ST_MUL, ST_ACC,
    ST_DEC, ST_QRY_MOD, ST_QRD, ST_QDAT, ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic do_write;
    logic do_start;
    logic mod_load_head;
    logic mod_load_q;
    logic mod_step;
    logic cur_load;
    logic rd_pair;
    logic rd_q;
    logic diff_load;
    logic mul;
    logic acc_add;
    logic step_commit;
    logic qmul;
    logic resp_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       q_ok;
    logic       cnt_gt2;
    logic       mod_done;
    logic       acc_neg;
    logic       mul_last;
    logic       out_free;
  } dp_sts_t;

  function automatic logic signed [31:0] sat_add32(logic signed [31:0] a,
                                                   logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      sat_add32 = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_add32 = s[31:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ design/waypoint_ring_sequencer.sv @@
`default_nettype none
// Waypoint ring sequencer: one result transaction per input transaction, in order. An advance
// reduces the head modulo the ring size, then tests one segment after another while more than
// two points remain; each test reads a waypoint pair from memory and sums the six partial
// products of the plane test, which share one 34 by 18 bit multiplier, and a negative sum
// stops the advance. An accepted query reduces head plus index modulo the ring size before its
// memory read. A result that waits for the receiver holds the block in its response state. The
// waypoint memory is not cleared at reset. A new input is taken while an earlier result still
// waits in the output register.
module waypoint_ring_sequencer #(
  parameter int RING_DEPTH = wrs_pkg::WRS_RING_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire wrs_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output wrs_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wrs_pkg::WRS_CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                       cfg_data
);
  import wrs_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  assign cfg_ready = 1'b1;

  wrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wrs_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire

@@ design/wrs_ctrl.sv @@
`default_nettype none
module wrs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire wrs_pkg::dp_sts_t  sts,
  output wrs_pkg::ctl_cmd_t      cmd
);
  import wrs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_DISP;
      ST_DISP: begin
        case (sts.kind)
          KIND_ADV:   state_nxt = ST_ADV_MOD;
          KIND_QUERY: state_nxt = sts.q_ok ? ST_QRY_MOD : ST_RESP;
          default:    state_nxt = ST_RESP;
        endcase
      end
      ST_ADV_MOD: if (sts.mod_done) state_nxt = ST_ADV_CHK;
      ST_ADV_CHK: state_nxt = sts.cnt_gt2 ? ST_RD : ST_RESP;
      ST_RD:      state_nxt = ST_DIFF;
      ST_DIFF:    state_nxt = ST_MUL;
      ST_MUL:     state_nxt = ST_ACC;
      ST_ACC:     state_nxt = sts.mul_last ? ST_DEC : ST_MUL;
      ST_DEC:     state_nxt = sts.acc_neg ? ST_RESP : ST_ADV_CHK;
      ST_QRY_MOD: if (sts.mod_done) state_nxt = ST_QRD;
      ST_QRD:     state_nxt = ST_QDAT;
      ST_QDAT:    state_nxt = ST_RESP;
      ST_RESP:    if (sts.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DISP: begin
        cmd.do_write      = (sts.kind == KIND_WRITE);
        cmd.do_start      = (sts.kind == KIND_START);
        cmd.mod_load_head = (sts.kind == KIND_ADV);
        cmd.mod_load_q    = (sts.kind == KIND_QUERY);
      end
      ST_ADV_MOD: begin
        cmd.mod_step = 1'b1;
        cmd.cur_load = sts.mod_done;
      end
      ST_RD:      cmd.rd_pair = 1'b1;
      ST_DIFF:    cmd.diff_load = 1'b1;
      ST_MUL:     cmd.mul = 1'b1;
      ST_ACC:     cmd.acc_add = 1'b1;
      ST_DEC:     cmd.step_commit = !sts.acc_neg;
      ST_QRY_MOD: cmd.mod_step = 1'b1;
      ST_QRD:     cmd.rd_q = 1'b1;
      ST_QDAT:    cmd.qmul = 1'b1;
      ST_RESP:    cmd.resp_load = sts.out_free;
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

@@ design/wrs_dp.sv @@
`default_nettype none
`include "waypoint_ring_sequencer_macros.svh"
module wrs_dp #(
  parameter int RING_DEPTH = wrs_pkg::WRS_RING_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire wrs_pkg::in_item_t                 in_data,
  input  wire logic                              cfg_valid,
  input  wire logic [wrs_pkg::WRS_CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                       cfg_data,
  input  wire wrs_pkg::ctl_cmd_t                 cmd,
  output wrs_pkg::dp_sts_t                       sts,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output wrs_pkg::out_item_t                     out_data
);
  import wrs_pkg::*;

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SZ_MAX_I = (RING_DEPTH < 127) ? RING_DEPTH : 127;
  localparam logic [WRS_POS_W-1:0] SZ_MAX = WRS_POS_W'(SZ_MAX_I);

  logic signed [31:0] shift_n_r, shift_e_r, shift_d_r;
  logic [31:0] gain_r;
  logic [6:0]  ring_size_r;

  in_item_t it_r;
  logic [WRS_POS_W-1:0] head_r, cnt_r, cur_r;
  logic [WRS_MOD_W-1:0] mod_r;

  wp_entry_t mem [RING_DEPTH];
  wp_entry_t rd0_r, rd1_r;

  logic signed [33:0] a_r [3];
  logic signed [32:0] b_r [3];
  logic signed [71:0] prod_r, acc_r;
  logic [2:0] p_r;
  logic [63:0] qprod_r;

  out_item_t out_r, out_nxt;
  logic out_valid_r;

  logic [WRS_POS_W-1:0] size_w, nx_w, cur_inc;
  logic [AW+WRS_MOD_W-1:0] mod_ext, cur_ext, nx_ext, slot_ext;

  always_comb begin
    size_w = ring_size_r;
    if (ring_size_r < 7'd2) size_w = 7'd2;
    if (ring_size_r > SZ_MAX) size_w = SZ_MAX;
  end

  assign cur_inc  = cur_r + 7'd1;
  assign nx_w     = (cur_inc == size_w) ? '0 : cur_inc;
  assign mod_ext  = (AW+WRS_MOD_W)'(mod_r);
  assign cur_ext  = (AW+WRS_MOD_W)'(cur_r);
  assign nx_ext   = (AW+WRS_MOD_W)'(nx_w);
  assign slot_ext = (AW+WRS_MOD_W)'(it_r.slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_n_r   <= '0;
      shift_e_r   <= '0;
      shift_d_r   <= '0;
      gain_r      <= 32'h0100_0000;
      ring_size_r <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SHIFT_N: shift_n_r   <= cfg_data;
        REG_SHIFT_E: shift_e_r   <= cfg_data;
        REG_SHIFT_D: shift_d_r   <= cfg_data;
        REG_GAIN:    gain_r      <= cfg_data;
        REG_SIZE:    ring_size_r <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) it_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.do_start && (7'(it_r.first_slot) < size_w)) begin
      head_r <= 7'(it_r.first_slot);
      cnt_r  <= (it_r.points_in_use > size_w) ? size_w : it_r.points_in_use;
    end else if (cmd.step_commit) begin
      head_r <= nx_w;
      cnt_r  <= cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_load_head) begin
      mod_r <= WRS_MOD_W'(head_r);
    end else if (cmd.mod_load_q) begin
      mod_r <= WRS_MOD_W'(head_r) + WRS_MOD_W'(it_r.rel_index);
    end else if (cmd.mod_step && (mod_r >= WRS_MOD_W'(size_w))) begin
      mod_r <= mod_r - WRS_MOD_W'(size_w);
    end
    if (cmd.cur_load) begin
      cur_r <= mod_r[WRS_POS_W-1:0];
    end else if (cmd.step_commit) begin
      cur_r <= nx_w;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_write && (32'(it_r.slot) < RING_DEPTH)) begin
      mem[slot_ext[AW-1:0]] <= {it_r.wp_north, it_r.wp_east, it_r.wp_down, it_r.wp_speed};
    end
    if (cmd.rd_pair) begin
      rd0_r <= mem[cur_ext[AW-1:0]];
      rd1_r <= mem[nx_ext[AW-1:0]];
    end else if (cmd.rd_q) begin
      rd0_r <= mem[mod_ext[AW-1:0]];
    end
  end

  logic signed [33:0] a_sel;
  logic signed [32:0] b_sel;
  logic signed [17:0] b_lo;
  logic signed [15:0] b_hi;

  always_comb begin
    case (p_r[2:1])
      2'd0:    begin a_sel = a_r[0]; b_sel = b_r[0]; end
      2'd1:    begin a_sel = a_r[1]; b_sel = b_r[1]; end
      default: begin a_sel = a_r[2]; b_sel = b_r[2]; end
    endcase
    b_lo = $signed({1'b0, b_sel[16:0]});
    b_hi = b_sel[32:17];
  end

  always_ff @(posedge clk) begin
    if (cmd.diff_load) begin
      a_r[0] <= 34'(it_r.own_north) - 34'(shift_n_r) - 34'(rd1_r.n);
      a_r[1] <= 34'(it_r.own_east)  - 34'(shift_e_r) - 34'(rd1_r.e);
      a_r[2] <= 34'(it_r.own_down)  - 34'(shift_d_r) - 34'(rd1_r.d);
      b_r[0] <= 33'(rd1_r.n) - 33'(rd0_r.n);
      b_r[1] <= 33'(rd1_r.e) - 33'(rd0_r.e);
      b_r[2] <= 33'(rd1_r.d) - 33'(rd0_r.d);
      acc_r  <= '0;
      p_r    <= '0;
    end
    if (cmd.mul) begin
      if (p_r[0]) begin
        prod_r <= 72'(a_sel * b_hi) <<< 17;
      end else begin
        prod_r <= 72'(a_sel * b_lo);
      end
    end
    if (cmd.acc_add) begin
      acc_r <= acc_r + prod_r;
      p_r   <= p_r + 3'd1;
    end
    if (cmd.qmul) qprod_r <= 64'(rd0_r.speed) * 64'(gain_r);
  end

  logic q_ok, start_ok, is_q;
  assign q_ok     = 7'(it_r.rel_index) < cnt_r;
  assign start_ok = 7'(it_r.first_slot) < size_w;
  assign is_q     = (it_r.kind == KIND_QUERY) && q_ok;

  always_comb begin
    out_nxt = '0;
    out_nxt.ok = is_q || ((it_r.kind == KIND_START) && start_ok);
    if (is_q) begin
      out_nxt.point_north = sat_add32(rd0_r.n, shift_n_r);
      out_nxt.point_east  = sat_add32(rd0_r.e, shift_e_r);
      out_nxt.point_down  = sat_add32(rd0_r.d, shift_d_r);
      out_nxt.point_speed = (|qprod_r[63:56]) ? 32'hffff_ffff : qprod_r[55:24];
    end
    out_nxt.seg_avail = cnt_r >= 7'd2;
    out_nxt.head_now  = head_r[5:0];
    out_nxt.count_now = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.kind     = it_r.kind;
  assign sts.q_ok     = q_ok;
  assign sts.cnt_gt2  = cnt_r > 7'd2;
  assign sts.mod_done = mod_r < WRS_MOD_W'(size_w);
  assign sts.acc_neg  = acc_r[71];
  assign sts.mul_last = p_r == 3'd5;
  assign sts.out_free = !out_valid_r || out_ready;

  `WRS_ASSERT_IMP(a_step_needs_count, cmd.step_commit, cnt_r > 7'd2)
  `WRS_ASSERT_NXT(a_step_dec_count, cmd.step_commit, cnt_r == $past(cnt_r) - 7'd1)
  `WRS_ASSERT_IMP(a_no_result_overwrite, cmd.resp_load, !out_valid_r || out_ready)
endmodule
`default_nettype wire
